[design/dsrc_pkg.sv]
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared constants, types and the IUPAC complement for the subsequence
// extractor.
// ----------------------------------------------------------------------------
package dsrc_pkg;

  localparam int LANES         = 8;
  localparam int BYTE_W        = 8;
  localparam int WORD_BYTES    = 8;
  localparam int WORD_W        = WORD_BYTES * BYTE_W;
  localparam int MAX_BASES_DEF = 512;
  localparam int EXT_W         = 10;
  localparam int CNT_W         = 4;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTRACT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVCOMP = 2'd2;

  localparam logic [EXT_W-1:0] EXTRACT_RESET = 10'd512;

  typedef logic [BYTE_W-1:0] base_t;

  // Control for one result word on its way from the store to the output
  typedef struct packed {
    logic [2:0]       off;   // byte offset of the anchor position in its word
    logic             rev;   // reverse and complement
    logic [CNT_W-1:0] n;     // valid bytes
    logic             last;
    logic             ovf;
    logic             wodd;  // low word of the window sits in the odd bank
  } emit_meta_t;

  // IUPAC complement, case kept, anything else gives N
  function automatic base_t complement(input base_t b);
    base_t r;
    case (b)
      "A": r = "T";
      "C": r = "G";
      "G": r = "C";
      "T": r = "A";
      "R": r = "Y";
      "Y": r = "R";
      "K": r = "M";
      "M": r = "K";
      "S": r = "S";
      "W": r = "W";
      "B": r = "V";
      "D": r = "H";
      "H": r = "D";
      "V": r = "B";
      "N": r = "N";
      "a": r = "t";
      "c": r = "g";
      "g": r = "c";
      "t": r = "a";
      "r": r = "y";
      "y": r = "r";
      "k": r = "m";
      "m": r = "k";
      "s": r = "s";
      "w": r = "w";
      "b": r = "v";
      "d": r = "h";
      "h": r = "d";
      "v": r = "b";
      "n": r = "n";
      default: r = "N";
    endcase
    return r;
  endfunction

endpackage

[design/dsrc_bank.sv]
// ----------------------------------------------------------------------------
// dsrc_bank
// One bank of the base store: byte-enable write, registered read.
// ----------------------------------------------------------------------------
module dsrc_bank #(
  parameter int ROWS   = 16,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [dsrc_pkg::WORD_BYTES-1:0] wbe,
  input  logic [dsrc_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [dsrc_pkg::WORD_W-1:0] rdata
);
  import dsrc_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WORD_BYTES; b++) begin
        if (wbe[b]) begin
          mem[waddr][b*BYTE_W +: BYTE_W] <= wdata[b*BYTE_W +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/dsrc_shape.sv]
// ----------------------------------------------------------------------------
// dsrc_shape
// Builds one result word from a two-word window read out of the banks:
// byte select, optional reverse complement, zero fill past the count.
// ----------------------------------------------------------------------------
module dsrc_shape (
  input  logic [dsrc_pkg::WORD_W-1:0]            even_rd,
  input  logic [dsrc_pkg::WORD_W-1:0]            odd_rd,
  input  dsrc_pkg::emit_meta_t                   meta,
  output logic [dsrc_pkg::LANES-1:0][dsrc_pkg::BYTE_W-1:0] bases
);
  import dsrc_pkg::*;

  logic [2*WORD_W-1:0] win;
  logic [3:0]          idx [LANES];

  assign win = meta.wodd ? {even_rd, odd_rd} : {odd_rd, even_rd};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      // reverse walks down from the anchor, which sits in the high word
      if (meta.rev) begin
        idx[i] = 4'd8 + {1'b0, meta.off} - 4'(i);
      end else begin
        idx[i] = {1'b0, meta.off} + 4'(i);
      end
      bases[i] = win[{idx[i], 3'b000} +: BYTE_W];
      if (meta.rev) begin
        bases[i] = complement(bases[i]);
      end
      if (4'(i) >= meta.n) begin
        bases[i] = '0;
      end
    end
  end

endmodule

[design/dna_subsequence_reverse_complement.sv]
// ----------------------------------------------------------------------------
// dna_subsequence_reverse_complement
// Collects an ASCII base sequence and emits a leading or trailing piece of
// it, as stored or reverse complemented.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while in_stall is low and written
// straight into a store of two byte-enabled banks (even and odd words of
// eight bases), so a group that straddles a word boundary lands in a single
// write. The word marked last is followed by a setup state, then result
// words leave at one per cycle while out_stall is low, each built from one
// read of both banks and passed through the registered bank read and the
// output register; input stays stalled until the final result word has been
// read out of the store. The store is not cleared after reset; only written
// bases are shown.
// ----------------------------------------------------------------------------
module dna_subsequence_reverse_complement #(
  parameter int MAX_BASES = dsrc_pkg::MAX_BASES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dsrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsrc_pkg::EXT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_base_0,
  input  logic [7:0]                     in_base_1,
  input  logic [7:0]                     in_base_2,
  input  logic [7:0]                     in_base_3,
  input  logic [7:0]                     in_base_4,
  input  logic [7:0]                     in_base_5,
  input  logic [7:0]                     in_base_6,
  input  logic [7:0]                     in_base_7,
  input  logic [3:0]                     in_count,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_base_0,
  output logic [7:0]                     out_base_1,
  output logic [7:0]                     out_base_2,
  output logic [7:0]                     out_base_3,
  output logic [7:0]                     out_base_4,
  output logic [7:0]                     out_base_5,
  output logic [7:0]                     out_base_6,
  output logic [7:0]                     out_base_7,
  output logic [3:0]                     out_count,
  output logic                           out_last,
  output logic                           overflowed
);
  import dsrc_pkg::*;

  localparam int WORDS  = (MAX_BASES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int ROWS   = (WORDS + 1) / 2;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLW    = $clog2(MAX_BASES + 1);
  localparam int PW     = SLW + 1;
  localparam int WW     = PW - 3;
  localparam int CW     = (SLW > EXT_W) ? SLW : EXT_W;
  localparam logic [WW-1:0]  ROWS_W  = WW'(ROWS);
  localparam logic [SLW-1:0] MAX_S   = SLW'(MAX_BASES);
  localparam logic [SLW-1:0] LANES_S = SLW'(LANES);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state;
  logic [EXT_W-1:0] extract_length;
  logic             take_prefix;
  logic             reverse_complement;
  logic [SLW-1:0]   stored_length;
  logic             overflow_seen;

  // load side
  logic                         in_acc;
  logic [LANES-1:0][BYTE_W-1:0] in_bytes;
  logic [CNT_W-1:0]             cnt_c;
  logic [SLW-1:0]               room;
  logic                         full_hit;
  logic [CNT_W-1:0]             take;
  logic [2:0]                   off_w;
  logic [WW-1:0]                w0;
  logic [WW-1:0]                w_row_a;
  logic [WW-1:0]                w_row_b;
  logic [2*WORD_BYTES-1:0]      wr_en;
  logic [2*WORD_BYTES-1:0][BYTE_W-1:0] wr_win;
  logic [WW-1:0]                ev_wrow;
  logic [WORD_BYTES-1:0]        ev_wbe;
  logic [WORD_W-1:0]            ev_wdata;
  logic                         ev_we;
  logic [WORD_BYTES-1:0]        od_wbe;
  logic [WORD_W-1:0]            od_wdata;
  logic                         od_we;

  // emit side
  logic [CW-1:0]     ext_c;
  logic [CW-1:0]     st_c;
  logic [SLW-1:0]    len_s;
  logic [PW-1:0]     pos;
  logic [SLW-1:0]    rem;
  logic [WW-1:0]     p_word;
  logic [WW-1:0]     wlo;
  logic [WW-1:0]     ev_rrow;
  logic [WW-1:0]     od_rrow;
  logic [CNT_W-1:0]  n_i;
  logic              last_i;
  logic              issue;
  logic              r_valid;
  logic              r_adv;
  emit_meta_t        r_meta;
  logic [WORD_W-1:0] ev_rd;
  logic [WORD_W-1:0] od_rd;
  logic [LANES-1:0][BYTE_W-1:0] shaped;

  // --------------------------------------------------------------------------
  // Load
  // --------------------------------------------------------------------------
  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign in_bytes = {in_base_7, in_base_6, in_base_5, in_base_4,
                     in_base_3, in_base_2, in_base_1, in_base_0};

  assign cnt_c    = (in_count > CNT_W'(LANES)) ? CNT_W'(LANES) : in_count;
  assign room     = MAX_S - stored_length;
  assign full_hit = SLW'(cnt_c) > room;
  assign take     = full_hit ? room[CNT_W-1:0] : cnt_c;
  assign off_w    = stored_length[2:0];
  assign w0       = WW'(stored_length >> 3);
  assign w_row_a  = w0 >> 1;
  assign w_row_b  = (w0 + WW'(1)) >> 1;

  // spread the group over a two-word window starting at the fill word
  always_comb begin
    for (int j = 0; j < 2*WORD_BYTES; j++) begin
      wr_en[j]  = (5'(j) >= {2'b00, off_w}) &&
                  (5'(j) < ({2'b00, off_w} + {1'b0, take}));
      wr_win[j] = in_bytes[3'(j) - off_w];
    end
  end

  always_comb begin
    if (w0[0]) begin
      ev_wrow  = w_row_b;
      ev_wbe   = wr_en[2*WORD_BYTES-1:WORD_BYTES];
      ev_wdata = wr_win[2*WORD_BYTES-1:WORD_BYTES];
      od_wbe   = wr_en[WORD_BYTES-1:0];
      od_wdata = wr_win[WORD_BYTES-1:0];
    end else begin
      ev_wrow  = w_row_a;
      ev_wbe   = wr_en[WORD_BYTES-1:0];
      ev_wdata = wr_win[WORD_BYTES-1:0];
      od_wbe   = wr_en[2*WORD_BYTES-1:WORD_BYTES];
      od_wdata = wr_win[2*WORD_BYTES-1:WORD_BYTES];
    end
  end

  assign ev_we = in_acc && (|ev_wbe) && (ev_wrow < ROWS_W);
  assign od_we = in_acc && (|od_wbe) && (w_row_a < ROWS_W);

  // --------------------------------------------------------------------------
  // Extract and emit
  // --------------------------------------------------------------------------
  assign ext_c = CW'(extract_length);
  assign st_c  = CW'(stored_length);
  assign len_s = SLW'((ext_c < st_c) ? ext_c : st_c);

  assign p_word  = WW'(pos >> 3);
  assign wlo     = reverse_complement ? (p_word - WW'(1)) : p_word;
  assign ev_rrow = ((wlo + WW'(1)) >> 1) < ROWS_W ? ((wlo + WW'(1)) >> 1) : '0;
  assign od_rrow = (wlo >> 1) < ROWS_W ? (wlo >> 1) : '0;

  assign n_i    = (rem >= LANES_S) ? CNT_W'(LANES) : rem[CNT_W-1:0];
  assign last_i = (rem <= LANES_S);
  assign r_adv  = r_valid && (!out_valid || !out_stall);
  assign issue  = (state == ST_EMIT) && (!r_valid || r_adv);

  dsrc_bank #(.ROWS(ROWS), .ADDR_W(RW)) u_bank_even (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_wrow[RW-1:0]),
    .wbe   (ev_wbe),
    .wdata (ev_wdata),
    .re    (issue),
    .raddr (ev_rrow[RW-1:0]),
    .rdata (ev_rd)
  );

  dsrc_bank #(.ROWS(ROWS), .ADDR_W(RW)) u_bank_odd (
    .clk   (clk),
    .we    (od_we),
    .waddr (w_row_a[RW-1:0]),
    .wbe   (od_wbe),
    .wdata (od_wdata),
    .re    (issue),
    .raddr (od_rrow[RW-1:0]),
    .rdata (od_rd)
  );

  dsrc_shape u_shape (
    .even_rd (ev_rd),
    .odd_rd  (od_rd),
    .meta    (r_meta),
    .bases   (shaped)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_LOAD;
      extract_length     <= EXTRACT_RESET;
      take_prefix        <= 1'b1;
      reverse_complement <= 1'b0;
      stored_length      <= '0;
      overflow_seen      <= 1'b0;
      r_valid            <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXTRACT: extract_length     <= cfg_data;
          CFG_PREFIX:  take_prefix        <= cfg_data[0];
          CFG_REVCOMP: reverse_complement <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            stored_length <= stored_length + SLW'(take);
            overflow_seen <= overflow_seen | full_hit;
            if (in_last) begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // drop the run once its final word is read out
          if (issue && last_i) begin
            state         <= ST_LOAD;
            stored_length <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      if (issue) begin
        r_valid <= 1'b1;
      end else if (r_adv) begin
        r_valid <= 1'b0;
      end

      if (r_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      rem <= len_s;
      if (reverse_complement) begin
        pos <= take_prefix ? (PW'(len_s) - PW'(1)) : (PW'(stored_length) - PW'(1));
      end else begin
        pos <= take_prefix ? '0 : (PW'(stored_length) - PW'(len_s));
      end
    end else if (issue) begin
      rem <= rem - SLW'(n_i);
      pos <= reverse_complement ? (pos - PW'(LANES)) : (pos + PW'(LANES));
    end

    if (issue) begin
      r_meta.off  <= pos[2:0];
      r_meta.rev  <= reverse_complement;
      r_meta.n    <= n_i;
      r_meta.last <= last_i;
      r_meta.ovf  <= overflow_seen;
      r_meta.wodd <= wlo[0];
    end

    if (r_adv) begin
      out_base_0 <= shaped[0];
      out_base_1 <= shaped[1];
      out_base_2 <= shaped[2];
      out_base_3 <= shaped[3];
      out_base_4 <= shaped[4];
      out_base_5 <= shaped[5];
      out_base_6 <= shaped[6];
      out_base_7 <= shaped[7];
      out_count  <= r_meta.n;
      out_last   <= r_meta.last;
      overflowed <= r_meta.ovf;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stored_length <= MAX_S)
    else $error("fill count beyond store capacity");

  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count < CNT_W'(LANES)) |-> out_last)
    else $error("partial result word not marked last");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    r_valid && out_valid && out_stall |=> r_valid)
    else $error("read data lost under output stall");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    issue && last_i |=> (stored_length == '0) && !overflow_seen && !in_stall)
    else $error("run state not cleared after final read");
`endif

endmodule
